### rtl/core/arrive_velocity_assert.svh
// Assertion macros shared by the RTL; empty bodies when SYNTH is defined.
`ifndef ARRIVE_VELOCITY_ASSERT_SVH
`define ARRIVE_VELOCITY_ASSERT_SVH
`ifndef SYNTH
// Check a property on clk_i, skipped while reset is asserted.
`define AV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("arrive_velocity assertion failed");
// Check a property on clk_i, also checked during reset.
`define AV_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("arrive_velocity reset assertion failed");
`else
`define AV_ASSERT(lbl, prop)
`define AV_ASSERT_NR(lbl, prop)
`endif
`endif

### rtl/core/av_pkg.sv
package av_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned ProdW  = 44;
  localparam int unsigned SqW    = 48;
  localparam int unsigned RootW  = 24;
  localparam int unsigned QuotW  = 25;
  localparam int unsigned DenW   = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 23;

  localparam logic [CfgIdxW-1:0] CfgTargetRadius = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSlowRadius   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxSpeed     = 2'd2;

  // Sideband carried through the square-root pipeline.
  typedef struct packed {
    logic             neg_x;
    logic             neg_y;
    logic             stop;
    logic             slow;
    logic [ProdW-1:0] px;
    logic [ProdW-1:0] py;
  } side_t;

  // Per-lane flags carried through a divider.
  typedef struct packed {
    logic neg;
    logic kill;
    logic stop;
  } lane_t;

endpackage

### rtl/core/av_sqrt.sv
module av_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [av_pkg::SqW-1:0]      sq_i,
  input  av_pkg::side_t               side_i,
  output logic                        vld_o,
  output logic [av_pkg::RootW-1:0]    root_o,
  output av_pkg::side_t               side_o
);
  import av_pkg::*;

  localparam int unsigned Steps = RootW;

  logic [SqW-1:0] n_q    [Steps];
  logic [SqW-1:0] root_q [Steps];
  side_t          side_q [Steps];
  logic           vld_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [SqW-1:0] Bit = SqW'(1) << (SqW - 2 - 2 * k);
    logic [SqW-1:0] n_in, r_in, sum, n_d, r_d;
    logic           v_in;
    side_t          s_in;

    if (k == 0) begin : g_first
      assign n_in = sq_i;
      assign r_in = '0;
      assign v_in = vld_i;
      assign s_in = side_i;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = root_q[k-1];
      assign v_in = vld_q[k-1];
      assign s_in = side_q[k-1];
    end

    // One root bit per stage: subtract when the trial fits.
    always_comb begin
      sum = r_in + Bit;
      if (n_in >= sum) begin
        n_d = n_in - sum;
        r_d = (r_in >> 1) + Bit;
      end else begin
        n_d = n_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= n_d;
        root_q[k] <= r_d;
        side_q[k] <= s_in;
      end
    end
  end

  assign vld_o  = vld_q[Steps-1];
  assign root_o = root_q[Steps-1][RootW-1:0];
  assign side_o = side_q[Steps-1];

endmodule

### rtl/core/av_div.sv
module av_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [av_pkg::ProdW-1:0]    num_i,
  input  logic [av_pkg::DenW-1:0]     den_i,
  input  av_pkg::lane_t               lane_i,
  output logic                        vld_o,
  output logic [av_pkg::QuotW-1:0]    quot_o,
  output logic                        ovf_o,
  output av_pkg::lane_t               lane_o
);
  import av_pkg::*;

  localparam int unsigned Stages = QuotW + 1;
  localparam int unsigned HiW    = ProdW - QuotW;

  logic [DenW-1:0]  r_q   [Stages];
  logic [QuotW-1:0] q_q   [Stages];
  logic [ProdW-1:0] num_q [Stages];
  logic [DenW-1:0]  den_q [Stages];
  logic             ovf_q [Stages];
  lane_t            lane_q[Stages];
  logic             vld_q [Stages];

  // Setup: the top bits must stay below the divisor or the quotient overflows.
  logic [HiW-1:0] hi;
  logic           ovf_d;
  assign hi    = num_i[ProdW-1:QuotW];
  assign ovf_d = DenW'(hi) >= den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= DenW'(hi);
      q_q[0]    <= '0;
      num_q[0]  <= num_i;
      den_q[0]  <= den_i;
      ovf_q[0]  <= ovf_d;
      lane_q[0] <= lane_i;
    end
  end

  for (genvar k = 1; k < Stages; k++) begin : g_step
    localparam int unsigned Bi = QuotW - k;
    logic [DenW:0]   t;
    logic [DenW-1:0] r_d;
    logic            b;

    // Restoring step: bring down one numerator bit.
    always_comb begin
      t = {r_q[k-1], num_q[k-1][Bi]};
      if (t >= {1'b0, den_q[k-1]}) begin
        b   = 1'b1;
        r_d = DenW'(t - {1'b0, den_q[k-1]});
      end else begin
        b   = 1'b0;
        r_d = t[DenW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= r_d;
        q_q[k]    <= {q_q[k-1][QuotW-2:0], b};
        num_q[k]  <= num_q[k-1];
        den_q[k]  <= den_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        lane_q[k] <= lane_q[k-1];
      end
    end
  end

  assign vld_o  = vld_q[Stages-1];
  assign quot_o = q_q[Stages-1];
  assign ovf_o  = ovf_q[Stages-1];
  assign lane_o = lane_q[Stages-1];

endmodule

### rtl/core/arrive_velocity.sv
// Arrive steering: per item, agent and target positions (signed Q16.8) give
// a desired velocity (signed Q16.8, saturated) and a stopped flag.
// Input channel: in_valid_i / in_stall_o with agent_x/y_i, target_x/y_i.
// Output channel: out_valid_o / out_stall_i with vel_x/y_o, stopped_o.
// A transfer happens at a clock edge with valid high and stall low.
// Config: cfg_valid_i / cfg_ready_o (always ready), cfg_index_i selects
// target_radius (0), slow_radius (1), max_speed (2); other indexes are
// dropped. Write config only while no item is in flight.
// Pipeline from input transfer to the result on out_valid_o: offset,
// products, 24 square-root stages, 26 divider stages, output.
// Throughput is one item per cycle while the pipeline advances; it has
// no loop, so every stage takes a new item each cycle it advances.
// Reset clears all valid bits and the config registers to zero.
// When the receiver stalls with a result pending the whole pipeline holds,
// and in_stall_o rises in the same cycle.
module arrive_velocity (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [23:0]            agent_x_i,
  input  logic signed [23:0]            agent_y_i,
  input  logic signed [23:0]            target_x_i,
  input  logic signed [23:0]            target_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [23:0]            vel_x_o,
  output logic signed [23:0]            vel_y_o,
  output logic                          stopped_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [av_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [av_pkg::CfgDatW-1:0]    cfg_data_i
);
  import av_pkg::*;

  `include "arrive_velocity_assert.svh"

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [22:0] target_radius_q;
  logic [22:0] slow_radius_q;
  logic [19:0] max_speed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_radius_q <= '0;
      slow_radius_q   <= '0;
      max_speed_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgTargetRadius: target_radius_q <= cfg_data_i;
        CfgSlowRadius:   slow_radius_q   <= cfg_data_i;
        CfgMaxSpeed:     max_speed_q     <= cfg_data_i[19:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Global advance: hold every stage while a finished result is stalled
  // ---------------------------------------------------------------------
  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------------------------------------------------------------
  // Stage A: saturated offset, magnitude and sign
  // ---------------------------------------------------------------------
  logic signed [PosW:0] dx_w, dy_w;
  logic [PosW-1:0]      dx_s, dy_s;
  logic [PosW-1:0]      ax_d, ay_d;
  logic                 a_vld_q;
  logic [PosW-1:0]      ax_q, ay_q;
  logic                 nx_q, ny_q;

  assign dx_w = {target_x_i[23], target_x_i} - {agent_x_i[23], agent_x_i};
  assign dy_w = {target_y_i[23], target_y_i} - {agent_y_i[23], agent_y_i};

  // Clamp the 25-bit difference to the signed 24-bit range.
  always_comb begin
    if (dx_w[PosW] != dx_w[PosW-1]) begin
      dx_s = dx_w[PosW] ? 24'h800000 : 24'h7FFFFF;
    end else begin
      dx_s = dx_w[PosW-1:0];
    end
    if (dy_w[PosW] != dy_w[PosW-1]) begin
      dy_s = dy_w[PosW] ? 24'h800000 : 24'h7FFFFF;
    end else begin
      dy_s = dy_w[PosW-1:0];
    end
    ax_d = dx_s[PosW-1] ? PosW'(-dx_s) : dx_s;
    ay_d = dy_s[PosW-1] ? PosW'(-dy_s) : dy_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
      nx_q <= dx_s[PosW-1];
      ny_q <= dy_s[PosW-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: squared distance, squared radii, speed products
  // ---------------------------------------------------------------------
  logic             b_vld_q;
  logic [SqW-1:0]   sq_q;
  logic [45:0]      tr2_q, sr2_q;
  logic [ProdW-1:0] px_q, py_q;
  logic             b_nx_q, b_ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q   <= SqW'(ax_q * ax_q) + SqW'(ay_q * ay_q);
      tr2_q  <= target_radius_q * target_radius_q;
      sr2_q  <= slow_radius_q * slow_radius_q;
      px_q   <= ax_q * max_speed_q;
      py_q   <= ay_q * max_speed_q;
      b_nx_q <= nx_q;
      b_ny_q <= ny_q;
    end
  end

  // ---------------------------------------------------------------------
  // Region test rides along the first square-root stage
  // ---------------------------------------------------------------------
  side_t side_in, side_out;
  logic  s_vld;
  logic [RootW-1:0] root;

  always_comb begin
    side_in.neg_x = b_nx_q;
    side_in.neg_y = b_ny_q;
    side_in.stop  = sq_q < SqW'(tr2_q);
    side_in.slow  = sq_q < SqW'(sr2_q);
    side_in.px    = px_q;
    side_in.py    = py_q;
  end

  av_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (b_vld_q),
    .sq_i   (sq_q),
    .side_i (side_in),
    .vld_o  (s_vld),
    .root_o (root),
    .side_o (side_out)
  );

  // ---------------------------------------------------------------------
  // Divisor choice: slow radius inside the slow zone, distance outside.
  // A zero divisor only happens on the target with a zero slow radius: zero output.
  // ---------------------------------------------------------------------
  logic [DenW-1:0] den;
  lane_t           lane_x_in, lane_y_in, lane_x_out, lane_y_out;
  logic            kill;

  assign den  = side_out.slow ? DenW'(slow_radius_q) : root;
  assign kill = side_out.stop || (den == '0);

  always_comb begin
    lane_x_in.neg  = side_out.neg_x;
    lane_x_in.kill = kill;
    lane_x_in.stop = side_out.stop;
    lane_y_in.neg  = side_out.neg_y;
    lane_y_in.kill = kill;
    lane_y_in.stop = side_out.stop;
  end

  logic             dvx, dvy;
  logic [QuotW-1:0] qx, qy;
  logic             ovx, ovy;

  av_div u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_vld),
    .num_i  (side_out.px),
    .den_i  (den),
    .lane_i (lane_x_in),
    .vld_o  (dvx),
    .quot_o (qx),
    .ovf_o  (ovx),
    .lane_o (lane_x_out)
  );

  av_div u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_vld),
    .num_i  (side_out.py),
    .den_i  (den),
    .lane_i (lane_y_in),
    .vld_o  (dvy),
    .quot_o (qy),
    .ovf_o  (ovy),
    .lane_o (lane_y_out)
  );

  // ---------------------------------------------------------------------
  // Output stage: apply sign, saturate, zero when stopped or killed
  // ---------------------------------------------------------------------
  logic [PosW-1:0] vx_d, vy_d;
  logic [PosW-1:0] vx_q, vy_q;
  logic            stop_q;

  function automatic logic [PosW-1:0] finish(input logic [QuotW-1:0] q, input logic ovf,
                                             input lane_t ln);
    logic            big;
    logic [PosW-1:0] mag;
    big = ovf || (q[QuotW-1:QuotW-2] != 2'b00);
    mag = PosW'(q);
    if (ln.kill) begin
      return '0;
    end else if (big) begin
      return ln.neg ? 24'h800000 : 24'h7FFFFF;
    end else begin
      return ln.neg ? PosW'(-mag) : mag;
    end
  endfunction

  assign vx_d = finish(qx, ovx, lane_x_out);
  assign vy_d = finish(qy, ovy, lane_y_out);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dvx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q   <= vx_d;
      vy_q   <= vy_d;
      stop_q <= lane_x_out.stop;
    end
  end

  assign out_valid_o = out_vld_q;
  assign vel_x_o     = vx_q;
  assign vel_y_o     = vy_q;
  assign stopped_o   = stop_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `AV_ASSERT(a_stop_zero, out_valid_o && stopped_o |-> vel_x_o == '0 && vel_y_o == '0)
  `AV_ASSERT(a_lanes_agree, dvx |-> dvy && lane_x_out.stop == lane_y_out.stop)
  `AV_ASSERT(a_stall_back, out_valid_o && out_stall_i |-> in_stall_o)
  `AV_ASSERT_NR(a_reset_idle, !rst_ni |-> !out_valid_o)

endmodule

### tb/arrive_velocity_tb.sv
module arrive_velocity_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import av_pkg::*;

  localparam longint PosMax = 64'sd8388607;
  localparam longint PosMin = -64'sd8388608;
  localparam int Latency = 53;
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;

  typedef struct packed {
    logic signed [23:0] agent_x;
    logic signed [23:0] agent_y;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
  } pos_item_t;

  typedef struct packed {
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic               stopped;
  } vel_item_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [23:0] agent_x_i, agent_y_i, target_x_i, target_y_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [23:0] vel_x_o, vel_y_o;
  logic stopped_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDatW-1:0] cfg_data_i;

  arrive_velocity u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .agent_x_i   (agent_x_i),
    .agent_y_i   (agent_y_i),
    .target_x_i  (target_x_i),
    .target_y_i  (target_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .vel_x_o     (vel_x_o),
    .vel_y_o     (vel_y_o),
    .stopped_o   (stopped_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock: 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of the steering registers.
  longint unsigned stop_radius_q, slow_radius_q, speed_q;

  pos_item_t pending_pos[$];
  vel_item_t expected_vel[$];
  int send_idle_pct, recv_idle_pct;
  int mismatches;
  bit in_took;

  function automatic longint clamp24(longint v);
    if (v > PosMax) return PosMax;
    if (v < PosMin) return PosMin;
    return v;
  endfunction

  // Isqrt, one bit pair at a time.
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // sign(d) * floor(|d| * mul / div), saturated.
  function automatic longint scale_axis(longint d, longint unsigned mul,
                                        longint unsigned div);
    longint unsigned mag;
    longint q;
    mag = (d < 0) ? -d : d;
    q = longint'((mag * mul) / div);
    return clamp24((d < 0) ? -q : q);
  endfunction

  function automatic vel_item_t steer(pos_item_t p);
    longint dx, dy;
    longint unsigned ax, ay, sq, span;
    vel_item_t v;
    dx = clamp24(longint'(p.target_x) - longint'(p.agent_x));
    dy = clamp24(longint'(p.target_y) - longint'(p.agent_y));
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sq = ax * ax + ay * ay;
    v = '0;
    if (sq < stop_radius_q * stop_radius_q) begin
      v.stopped = 1'b1;
    end else if (sq < slow_radius_q * slow_radius_q) begin
      v.vel_x = 24'(scale_axis(dx, speed_q, slow_radius_q));
      v.vel_y = 24'(scale_axis(dy, speed_q, slow_radius_q));
    end else begin
      span = floor_sqrt(sq);
      if (span != 0) begin
        v.vel_x = 24'(scale_axis(dx, speed_q, span));
        v.vel_y = 24'(scale_axis(dy, speed_q, span));
      end
    end
    return v;
  endfunction

  // Record an input transfer at the rising edge where it happens.
  always @(posedge clk_i) begin
    in_took <= in_valid_i && !in_stall_o;
  end

  // Driver: present the queue head at the falling edge, advance on transfer.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_took) begin
        // Head was transferred at the last rising edge.
        expected_vel.push_back(steer(pending_pos.pop_front()));
      end
      if (in_valid_i && !in_took) begin
        // Stalled: hold the payload.
      end else if (pending_pos.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        agent_x_i  <= pending_pos[0].agent_x;
        agent_y_i  <= pending_pos[0].agent_y;
        target_x_i <= pending_pos[0].target_x;
        target_y_i <= pending_pos[0].target_y;
      end else begin
        in_valid_i <= 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: check each output transfer against the oldest expectation.
  always @(posedge clk_i) begin
    vel_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_vel.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: vel %0d,%0d stopped %0b",
                   vel_x_o, vel_y_o, stopped_o);
      end else begin
        want = expected_vel.pop_front();
        if (want.vel_x !== vel_x_o || want.vel_y !== vel_y_o ||
            want.stopped !== stopped_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp vel %0d,%0d stop %0b got %0d,%0d stop %0b",
                     want.vel_x, want.vel_y, want.stopped,
                     vel_x_o, vel_y_o, stopped_o);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_pos.size() != 0 || expected_vel.size() != 0 || in_valid_i)
      @(negedge clk_i);
    repeat (Latency + 5) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, longint unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgDatW'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgTargetRadius: stop_radius_q = val & 64'h7FFFFF;
      CfgSlowRadius:   slow_radius_q = val & 64'h7FFFFF;
      CfgMaxSpeed:     speed_q       = val & 64'hFFFFF;
      default: ;
    endcase
  endtask

  task automatic setup(longint unsigned tr, longint unsigned sr,
                       longint unsigned ms);
    write_reg(CfgTargetRadius, tr);
    write_reg(CfgSlowRadius, sr);
    write_reg(CfgMaxSpeed, ms);
  endtask

  task automatic add_pos(longint ax, longint ay, longint tx, longint ty);
    pos_item_t p;
    p.agent_x = 24'(ax);
    p.agent_y = 24'(ay);
    p.target_x = 24'(tx);
    p.target_y = 24'(ty);
    pending_pos.push_back(p);
  endtask

  // Random position; mostly near the agent so all regions get hit.
  function automatic longint rand_offset(int scale);
    case (scale)
      0: return longint'($urandom_range(64)) - 32;
      1: return longint'($urandom_range(8192)) - 4096;
      2: return longint'($urandom_range(1 << 20)) - (1 << 19);
      default: return longint'($signed(24'($urandom)));
    endcase
  endfunction

  task automatic add_random(int n);
    longint ax, ay;
    int scale;
    repeat (n) begin
      ax = longint'($signed(24'($urandom)));
      ay = longint'($signed(24'($urandom)));
      scale = $urandom_range(3);
      if (scale == 3)
        add_pos(ax, ay, rand_offset(3), rand_offset(3));
      else
        add_pos(ax, ay, clamp24(ax + rand_offset(scale)),
                clamp24(ay + rand_offset(scale)));
    end
  endtask

  task automatic random_config();
    longint unsigned tr, sr;
    tr = $urandom_range(3) == 0 ? 0 : $urandom_range(2048);
    sr = tr + $urandom_range(1 << 14);
    setup(tr, sr, $urandom_range(20'hFFFFF));
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    agent_x_i = '0;
    agent_y_i = '0;
    target_x_i = '0;
    target_y_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    stop_radius_q = 0;
    slow_radius_q = 0;
    speed_q = 0;
    mismatches = 0;
    send_idle_pct = 13;
    recv_idle_pct = 54;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset config, zero distance with zero radii, then extremes.
    add_pos(0, 0, 0, 0);
    add_pos(0, 0, 256, 0);
    wait_drained();
    setup(256, 4096, 20'hFFFFF);
    add_pos(0, 0, 0, 0);                     // stopped on target
    add_pos(0, 0, 100, -100);                // inside stop radius
    add_pos(0, 0, 1000, -2000);              // slow region
    add_pos(0, 0, -100000, 50000);           // cruise
    add_pos(PosMin, PosMin, PosMax, PosMax); // offsets saturate
    add_pos(PosMax, PosMax, PosMin, PosMin);
    add_pos(PosMax, 0, PosMin, 0);
    add_pos(0, PosMin, 0, PosMax);
    add_pos(-1, -1, -1, -1);
    wait_drained();
    write_reg(CfgNoReg, 23'h7FFFFF);         // unused index, dropped
    setup(23'h7FFFFF, 23'h7FFFFF, 0);
    add_pos(0, 0, PosMax, PosMax);
    add_pos(0, 0, 5, 5);
    wait_drained();
    setup(0, 23'h7FFFFF, 20'hFFFFF);         // huge slow radius
    add_pos(PosMin, 0, PosMax, 0);
    add_pos(0, 0, 1, 0);
    add_pos(0, 0, 0, 0);
    wait_drained();
    setup(0, 1, 20'hFFFFF);                  // tiny slow radius
    add_pos(0, 0, 0, 0);
    add_pos(0, 0, 1, 1);
    add_pos(0, 0, PosMax, PosMin);
    wait_drained();

    // Random phases: one idle mix each, new settings between.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 54 : 0;
      recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 13 : 0;
      for (int k = 0; k < 3; k++) begin
        random_config();
        add_random(205);
        wait_drained();
      end
    end
    // Final wait happened in wait_drained.
    if (mismatches == 0) begin
      $display("arrive_velocity_tb: clean");
    end else begin
      $display("arrive_velocity_tb: errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("arrive_velocity_tb: errors");
    $finish;
  end

endmodule
